@@ rtl/wst_pkg.sv @@
// ----------------------------------------------------------------------------
// Wear and sleep tracker package
// Shared types, operation and mode codes, and register indexes.
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam int unsigned POLL_MINUTES = 15;
  localparam logic [31:0] POLL_SECONDS = 32'(POLL_MINUTES * 60);

  localparam logic [1:0] OP_POLL  = 2'd0;
  localparam logic [1:0] OP_WAKE  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [1:0] MODE_AWAKE  = 2'd0;
  localparam logic [1:0] MODE_ASLEEP = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd2;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_OFF_DROP    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SLEEP   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NIGHT_START = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NIGHT_END   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NAP_START   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NAP_END     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NIGHT_POLLS = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NAP_POLLS   = 4'd7;

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 240;
  localparam int unsigned OUT_USER_W = 2;

  typedef struct packed {
    logic [9:0]  off_drop;
    logic [16:0] min_sleep;
    logic [4:0]  night_start;
    logic [4:0]  night_end;
    logic [4:0]  nap_start;
    logic [4:0]  nap_end;
    logic [7:0]  night_polls;
    logic [7:0]  nap_polls;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        now;
    logic signed [15:0] temp;
    logic               temp_valid;
    logic [31:0]        steps;
    logic [4:0]         hour;
  } item_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        wake_at;
    logic [31:0]        sleep_from;
    logic [31:0]        still_from;
    logic [31:0]        wear_from;
    logic [31:0]        off_from;
    logic [7:0]         still_cnt;
    logic [31:0]        prev_steps;
    logic signed [15:0] avg;
    logic [3:0]         samples;
    logic [31:0]        sleep_len;
    logic [31:0]        off_len;
    logic [31:0]        longest_wear;
  } state_t;

endpackage

@@ rtl/wst_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Wear and sleep tracker configuration registers
// Holds the thresholds and hour windows written through the config channel.
// ----------------------------------------------------------------------------
module wst_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [wst_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [wst_pkg::CFG_DATA_W-1:0]   wr_data,
  output wst_pkg::cfg_t                    cfg
);
  import wst_pkg::*;

  cfg_t cfg_r;

  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_drop    <= 10'd30;
      cfg_r.min_sleep   <= 17'd1800;
      cfg_r.night_start <= 5'd22;
      cfg_r.night_end   <= 5'd8;
      cfg_r.nap_start   <= 5'd13;
      cfg_r.nap_end     <= 5'd18;
      cfg_r.night_polls <= 8'd3;
      cfg_r.nap_polls   <= 8'd2;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_OFF_DROP:    cfg_r.off_drop    <= wr_data[9:0];
        REG_MIN_SLEEP:   cfg_r.min_sleep   <= wr_data[16:0];
        REG_NIGHT_START: cfg_r.night_start <= wr_data[4:0];
        REG_NIGHT_END:   cfg_r.night_end   <= wr_data[4:0];
        REG_NAP_START:   cfg_r.nap_start   <= wr_data[4:0];
        REG_NAP_END:     cfg_r.nap_end     <= wr_data[4:0];
        REG_NIGHT_POLLS: cfg_r.night_polls <= wr_data[7:0];
        REG_NAP_POLLS:   cfg_r.nap_polls   <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/wst_update.sv @@
// ----------------------------------------------------------------------------
// Wear and sleep tracker state update
// Next-state logic for one operation: start, poll or manual wake.
// ----------------------------------------------------------------------------
module wst_update (
  input  wst_pkg::cfg_t   cfg,
  input  wst_pkg::state_t st,
  input  wst_pkg::item_t  item,
  output wst_pkg::state_t st_nxt
);
  import wst_pkg::*;

  function automatic logic [31:0] span(input logic [31:0] now, input logic [31:0] from);
    span = (now > from) ? (now - from) : 32'd0;
  endfunction

  logic               tvalid;
  logic signed [17:0] drop_diff;
  logic signed [17:0] drop_lim;
  logic               off_det;
  logic               moved;
  logic [31:0]        sleep_span;
  logic [31:0]        off_span;
  logic [31:0]        wear_span;
  logic signed [19:0] avg_x;
  logic signed [19:0] temp_x;
  logic signed [19:0] avg_sum;
  logic signed [19:0] avg_adj;
  logic signed [15:0] avg_new;
  logic               is_night;
  logic               in_nap;
  logic               in_win;
  logic [7:0]         need;
  logic [7:0]         still_inc;

  // The most negative code marks a missing reading.
  assign tvalid    = item.temp_valid && (item.temp != 16'sh8000);
  assign drop_diff = {{2{st.avg[15]}}, st.avg} - {{2{item.temp[15]}}, item.temp};
  assign drop_lim  = $signed({8'b0, cfg.off_drop});
  assign off_det   = tvalid && (st.samples >= 4'd3) && (drop_diff >= drop_lim);
  assign moved     = item.steps > st.prev_steps;

  assign sleep_span = span(item.now, st.sleep_from);
  assign off_span   = span(item.now, st.off_from);
  assign wear_span  = span(item.now, st.wear_from);

  // Average of seven parts old and one part new, rounded by adding four, then
  // divided by eight with truncation towards zero.
  assign avg_x   = {{4{st.avg[15]}}, st.avg};
  assign temp_x  = {{4{item.temp[15]}}, item.temp};
  assign avg_sum = (avg_x <<< 3) - avg_x + temp_x + 20'sd4;
  assign avg_adj = avg_sum[19] ? (avg_sum + 20'sd7) : avg_sum;
  assign avg_new = avg_adj[18:3];

  assign is_night  = (item.hour >= cfg.night_start) || (item.hour < cfg.night_end);
  assign in_nap    = (item.hour >= cfg.nap_start) && (item.hour < cfg.nap_end);
  assign in_win    = is_night || in_nap;
  assign need      = in_nap ? cfg.nap_polls : cfg.night_polls;
  assign still_inc = st.still_cnt + 8'd1;

  always_comb begin
    st_nxt = st;
    unique case (item.opcode)
      OP_POLL: begin
        st_nxt.prev_steps = item.steps;
        if (off_det) begin
          if (st.mode != MODE_OFF) begin
            if ((st.mode == MODE_ASLEEP) && (st.sleep_from != 32'd0)) begin
              if (sleep_span >= {15'b0, cfg.min_sleep}) begin
                st_nxt.sleep_len = sleep_span;
              end
              st_nxt.sleep_from = 32'd0;
            end
            st_nxt.off_from  = item.now;
            st_nxt.still_cnt = 8'd0;
          end
          st_nxt.mode = MODE_OFF;
        end else if (st.mode == MODE_OFF) begin
          if (off_span != 32'd0) begin
            st_nxt.off_len = off_span;
          end
          st_nxt.wear_from = item.now;
          st_nxt.mode      = MODE_AWAKE;
          st_nxt.wake_at   = item.now;
          st_nxt.still_cnt = 8'd0;
        end else begin
          if (tvalid) begin
            if (st.samples == 4'd0) begin
              st_nxt.avg     = item.temp;
              st_nxt.samples = 4'd1;
            end else begin
              if (st.samples < 4'd8) begin
                st_nxt.samples = st.samples + 4'd1;
              end
              st_nxt.avg = avg_new;
            end
          end
          if (wear_span > st.longest_wear) begin
            st_nxt.longest_wear = wear_span;
          end
          if (st.mode == MODE_ASLEEP) begin
            if (moved || !in_win) begin
              if (st.sleep_from != 32'd0) begin
                if (sleep_span >= {15'b0, cfg.min_sleep}) begin
                  st_nxt.sleep_len = sleep_span;
                end
                st_nxt.sleep_from = 32'd0;
              end
              st_nxt.mode      = MODE_AWAKE;
              st_nxt.wake_at   = item.now;
              st_nxt.still_cnt = 8'd0;
            end
          end else if (moved || !in_win) begin
            st_nxt.still_cnt = 8'd0;
          end else begin
            // The first still poll backdates the candidate sleep start.
            if (st.still_cnt == 8'd0) begin
              st_nxt.still_from = item.now - POLL_SECONDS;
            end
            st_nxt.still_cnt = still_inc;
            if (still_inc >= need) begin
              st_nxt.mode       = MODE_ASLEEP;
              st_nxt.sleep_from = (st.still_cnt == 8'd0) ? (item.now - POLL_SECONDS)
                                                         : st.still_from;
              st_nxt.still_cnt  = 8'd0;
            end
          end
        end
      end
      OP_WAKE: begin
        st_nxt.mode      = MODE_AWAKE;
        st_nxt.wake_at   = item.now;
        st_nxt.still_cnt = 8'd0;
      end
      OP_START: begin
        st_nxt           = '0;
        st_nxt.mode      = MODE_AWAKE;
        st_nxt.wake_at   = item.now;
        st_nxt.wear_from = item.now;
        if (tvalid) begin
          st_nxt.avg     = item.temp;
          st_nxt.samples = 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/wear_and_sleep_tracker.sv @@
// ----------------------------------------------------------------------------
// Wear and sleep tracker
// Tracks wrist wear, off-wrist periods and sleep from periodic polls.
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid/in_tready    in_tdata, in_tuser
//   out_     master     out_tvalid/out_tready  out_tdata, out_tuser
//   cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Each beat is processed combinationally; its result appears in the output
// register on the following cycle, one result per input beat.
// A new beat is taken every cycle while the output register is empty or
// being drained, so a stalled result holds only the input channel.
// Reset is synchronous and restores all statistics and register defaults;
// configuration writes are always taken outside reset.
// ----------------------------------------------------------------------------
module wear_and_sleep_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // now_seconds[31:0], temp_tenths[47:32], step_total[79:48],
  // hour_of_day[84:80], zero pad [87:85]
  input  logic [wst_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode[1:0], temp_valid[2]
  input  logic [wst_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // wake_time[31:0], sleep_start_time[63:32], wear_start_time[95:64],
  // off_start_time[127:96], last_sleep_length[159:128],
  // last_off_length[191:160], longest_wear_length[223:192],
  // temp_baseline[239:224]
  output logic [wst_pkg::OUT_DATA_W-1:0]    out_tdata,
  // mode_now[1:0]
  output logic [wst_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wst_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wst_pkg::*;

  cfg_t                    cfg;
  item_t                   item;
  state_t                  state_r;
  state_t                  state_nxt;
  logic                    in_beat;
  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;
  logic [OUT_USER_W-1:0]   out_tuser_r;

  assign cfg_ready = rst_n;
  assign in_tready = rst_n && (!out_tvalid_r || out_tready);
  assign in_beat   = in_tvalid && in_tready;

  assign item.opcode     = in_tuser[1:0];
  assign item.temp_valid = in_tuser[2];
  assign item.now        = in_tdata[31:0];
  assign item.temp       = $signed(in_tdata[47:32]);
  assign item.steps      = in_tdata[79:48];
  assign item.hour       = in_tdata[84:80];

  wst_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  wst_update u_update (
    .cfg    (cfg),
    .st     (state_r),
    .item   (item),
    .st_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_beat) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_beat) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_tdata_r <= {state_nxt.avg, state_nxt.longest_wear, state_nxt.off_len,
                      state_nxt.sleep_len, state_nxt.off_from, state_nxt.wear_from,
                      state_nxt.sleep_from, state_nxt.wake_at};
      out_tuser_r <= state_nxt.mode;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

@@ rtl/wst_checker.sv @@
// ----------------------------------------------------------------------------
// Wear and sleep tracker checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module wst_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [wst_pkg::IN_DATA_W-1:0]     in_tdata,
  input logic [wst_pkg::IN_USER_W-1:0]     in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [wst_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic [wst_pkg::OUT_USER_W-1:0]    out_tuser
);
  import wst_pkg::*;

  logic in_beat;
  assign in_beat = in_tvalid && in_tready;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // Every accepted beat yields a result on the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> out_tvalid)
    else $error("no result after accepted beat");

  // Start clears the statistics and stamps the wake and wear times.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_tuser[1:0] == OP_START) |=>
      (out_tuser == MODE_AWAKE) && (out_tdata[31:0] == $past(in_tdata[31:0])) &&
      (out_tdata[95:64] == $past(in_tdata[31:0])) && (out_tdata[63:32] == 32'd0) &&
      (out_tdata[223:96] == '0))
    else $error("start did not clear state");

  // A manual wake always leaves the tracker awake, woken now.
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_tuser[1:0] == OP_WAKE) |=>
      (out_tuser == MODE_AWAKE) && (out_tdata[31:0] == $past(in_tdata[31:0])))
    else $error("manual wake not reflected");

endmodule

bind wear_and_sleep_tracker wst_checker u_wst_checker (.*);

@@ tb/wear_and_sleep_tracker_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wear and sleep tracker testbench
// Drives start, poll, manual wake and unused-opcode beats through the stream port, keeps a
// behavioural tracker of its own and compares every result beat field by
// field. A directed table comes first, then random phases under different
// register settings and idling patterns.
// ----------------------------------------------------------------------------
module wear_and_sleep_tracker_test;
  import wst_pkg::*;

  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam logic [3:0]  REG_SPARE   = 4'd15;
  localparam logic [15:0] NO_READING  = 16'h8000;
  localparam int          QUIET_LIMIT = 1000;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          PHASE_BEATS = 240;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        wake_time;
    logic [31:0]        sleep_start;
    logic [31:0]        wear_start;
    logic [31:0]        off_start;
    logic [31:0]        sleep_len;
    logic [31:0]        off_len;
    logic [31:0]        longest_wear;
    logic signed [15:0] baseline;
  } status_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        wake_at;
    logic [31:0]        sleep_from;
    logic [31:0]        still_from;
    logic [31:0]        wear_from;
    logic [31:0]        off_from;
    logic [7:0]         still_cnt;
    logic [31:0]        last_steps;
    logic signed [15:0] baseline;
    logic [3:0]         samples;
    logic [31:0]        sleep_len;
    logic [31:0]        off_len;
    logic [31:0]        longest_wear;
  } tracker_t;

  typedef struct packed {
    item_t   it;
    logic    known;
    status_t st;
  } step_row_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wear_and_sleep_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker model, its settings and the results still owed by the block.
  tracker_t    trk;
  cfg_t        regs;
  status_t     status_q[$];
  step_row_t   pinned_q[$];
  step_row_t   plan[$];
  reg_write_t  write_q[$];
  int          mismatches = 0;
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  logic [31:0] sim_now;
  logic [31:0] sim_steps;
  logic [4:0]  sim_hour;
  int          dip_left;

  function automatic logic [31:0] span_of(input logic [31:0] upto, input logic [31:0] from);
    return (upto > from) ? upto - from : 32'd0;
  endfunction

  task automatic end_sleep(input logic [31:0] now);
    logic [31:0] dur;
    if (trk.sleep_from != 32'd0) begin
      dur = span_of(now, trk.sleep_from);
      if (dur >= 32'(regs.min_sleep)) trk.sleep_len = dur;
      trk.sleep_from = 32'd0;
    end
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_OFF_DROP:    regs.off_drop = data[9:0];
      REG_MIN_SLEEP:   regs.min_sleep = data[16:0];
      REG_NIGHT_START: regs.night_start = data[4:0];
      REG_NIGHT_END:   regs.night_end = data[4:0];
      REG_NAP_START:   regs.nap_start = data[4:0];
      REG_NAP_END:     regs.nap_end = data[4:0];
      REG_NIGHT_POLLS: regs.night_polls = data[7:0];
      REG_NAP_POLLS:   regs.nap_polls = data[7:0];
      default: ;
    endcase
  endtask

  task automatic advance_tracker(input item_t it, output status_t st);
    logic        present, moved, night, nap, window;
    logic [7:0]  need;
    logic [31:0] dur;
    int          mean;
    present = it.temp_valid && ($unsigned(it.temp) != NO_READING);
    mean = int'(trk.baseline);
    case (it.opcode)
      OP_POLL: begin
        moved = it.steps > trk.last_steps;
        trk.last_steps = it.steps;
        if (present && trk.samples >= 4'd3 &&
            (mean - int'(it.temp)) >= int'({1'b0, regs.off_drop})) begin
          if (trk.mode != MODE_OFF) begin
            if (trk.mode == MODE_ASLEEP) end_sleep(it.now);
            trk.off_from = it.now;
            trk.still_cnt = 8'd0;
          end
          trk.mode = MODE_OFF;
        end else if (trk.mode == MODE_OFF) begin
          dur = span_of(it.now, trk.off_from);
          if (dur != 32'd0) trk.off_len = dur;
          trk.wear_from = it.now;
          trk.mode = MODE_AWAKE;
          trk.wake_at = it.now;
          trk.still_cnt = 8'd0;
        end else begin
          if (present) begin
            if (trk.samples == 4'd0) begin
              trk.baseline = it.temp;
              trk.samples = 4'd1;
            end else begin
              if (trk.samples < 4'd8) trk.samples = trk.samples + 4'd1;
              // Signed division in SystemVerilog truncates toward zero.
              trk.baseline = 16'((mean * 7 + int'(it.temp) + 4) / 8);
            end
          end
          dur = span_of(it.now, trk.wear_from);
          if (dur > trk.longest_wear) trk.longest_wear = dur;
          night = (it.hour >= regs.night_start) || (it.hour < regs.night_end);
          nap = (it.hour >= regs.nap_start) && (it.hour < regs.nap_end);
          window = night || nap;
          need = nap ? regs.nap_polls : regs.night_polls;
          if (trk.mode == MODE_ASLEEP) begin
            if (moved || !window) begin
              end_sleep(it.now);
              trk.mode = MODE_AWAKE;
              trk.wake_at = it.now;
              trk.still_cnt = 8'd0;
            end
          end else if (moved || !window) begin
            trk.still_cnt = 8'd0;
          end else begin
            // The sleep start is backdated by one poll interval.
            if (trk.still_cnt == 8'd0) trk.still_from = it.now - POLL_SECONDS;
            trk.still_cnt = trk.still_cnt + 8'd1;
            if (trk.still_cnt >= need) begin
              trk.mode = MODE_ASLEEP;
              trk.sleep_from = trk.still_from;
              trk.still_cnt = 8'd0;
            end
          end
        end
      end
      OP_WAKE: begin
        trk.mode = MODE_AWAKE;
        trk.wake_at = it.now;
        trk.still_cnt = 8'd0;
      end
      OP_START: begin
        trk = '0;
        trk.wake_at = it.now;
        trk.wear_from = it.now;
        if (present) begin
          trk.baseline = it.temp;
          trk.samples = 4'd1;
        end
      end
      default: ;
    endcase
    st.mode = trk.mode;
    st.wake_time = trk.wake_at;
    st.sleep_start = trk.sleep_from;
    st.wear_start = trk.wear_from;
    st.off_start = trk.off_from;
    st.sleep_len = trk.sleep_len;
    st.off_len = trk.off_len;
    st.longest_wear = trk.longest_wear;
    st.baseline = trk.baseline;
  endtask

  always @(posedge clk) begin : scoreboard
    item_t   it;
    status_t want, got;
    step_row_t pin;
    string   detail;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) set_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        it.opcode = in_tuser[1:0];
        it.temp_valid = in_tuser[2];
        it.now = in_tdata[31:0];
        it.temp = in_tdata[47:32];
        it.steps = in_tdata[79:48];
        it.hour = in_tdata[84:80];
        advance_tracker(it, want);
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.known) want = pin.st;
        end
        status_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.mode = out_tuser[1:0];
        got.wake_time = out_tdata[31:0];
        got.sleep_start = out_tdata[63:32];
        got.wear_start = out_tdata[95:64];
        got.off_start = out_tdata[127:96];
        got.sleep_len = out_tdata[159:128];
        got.off_len = out_tdata[191:160];
        got.longest_wear = out_tdata[223:192];
        got.baseline = out_tdata[239:224];
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing outstanding: mode=%0d wake=%h",
                     $realtime, got.mode, got.wake_time);
        end else begin
          want = status_q.pop_front();
          detail = "";
          if (got.mode !== want.mode)
            detail = {detail, $sformatf(" mode exp %0d got %0d", want.mode, got.mode)};
          if (got.wake_time !== want.wake_time)
            detail = {detail, $sformatf(" wake exp %h got %h", want.wake_time,
                                        got.wake_time)};
          if (got.sleep_start !== want.sleep_start)
            detail = {detail, $sformatf(" sleep_start exp %h got %h", want.sleep_start,
                                        got.sleep_start)};
          if (got.wear_start !== want.wear_start)
            detail = {detail, $sformatf(" wear_start exp %h got %h", want.wear_start,
                                        got.wear_start)};
          if (got.off_start !== want.off_start)
            detail = {detail, $sformatf(" off_start exp %h got %h", want.off_start,
                                        got.off_start)};
          if (got.sleep_len !== want.sleep_len)
            detail = {detail, $sformatf(" sleep_len exp %h got %h", want.sleep_len,
                                        got.sleep_len)};
          if (got.off_len !== want.off_len)
            detail = {detail, $sformatf(" off_len exp %h got %h", want.off_len,
                                        got.off_len)};
          if (got.longest_wear !== want.longest_wear)
            detail = {detail, $sformatf(" longest exp %h got %h", want.longest_wear,
                                        got.longest_wear)};
          if (got.baseline !== want.baseline)
            detail = {detail, $sformatf(" baseline exp %0d got %0d", want.baseline,
                                        got.baseline)};
          if (detail != "") begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: result mismatch:%s", $realtime, detail);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= (int'($urandom_range(99)) >= stall_pct);
  end

  // Ends the run if the block stops taking or giving beats.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic item_t beat_of(input logic [1:0] op, input logic [31:0] now,
                                    input logic [15:0] temp, input logic valid,
                                    input logic [31:0] steps, input logic [4:0] hour);
    item_t it;
    it.opcode = op;
    it.now = now;
    it.temp = temp;
    it.temp_valid = valid;
    it.steps = steps;
    it.hour = hour;
    return it;
  endfunction

  function automatic status_t started(input logic [31:0] at, input logic [15:0] temp);
    status_t st;
    st = '0;
    st.mode = MODE_AWAKE;
    st.wake_time = at;
    st.wear_start = at;
    st.baseline = temp;
    return st;
  endfunction

  task automatic add_row(input item_t it, input logic known, input status_t st);
    step_row_t r;
    r.it = it;
    r.known = known;
    r.st = st;
    plan.push_back(r);
  endtask

  task automatic offer(input item_t it);
    while (int'($urandom_range(99)) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, it.hour, it.steps, it.temp, it.now};
    in_tuser <= {it.temp_valid, it.opcode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [16:0] drop, input logic [16:0] min_sleep,
                              input logic [16:0] n_start, input logic [16:0] n_end,
                              input logic [16:0] p_start, input logic [16:0] p_end,
                              input logic [16:0] n_polls, input logic [16:0] p_polls);
    reg_write_t w;
    write_q.push_back({REG_OFF_DROP, drop});
    write_q.push_back({REG_MIN_SLEEP, min_sleep});
    write_q.push_back({REG_NIGHT_START, n_start});
    write_q.push_back({REG_NIGHT_END, n_end});
    write_q.push_back({REG_NAP_START, p_start});
    write_q.push_back({REG_NAP_END, p_end});
    write_q.push_back({REG_NIGHT_POLLS, n_polls});
    write_q.push_back({REG_NAP_POLLS, p_polls});
    while (write_q.size() != 0) begin
      w = write_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random beats follow a simulated day: regular polls with mostly still
  // wrists, off-wrist dips, starts and wakes, plus a share of pure noise.
  task automatic run_random(input int count);
    item_t it;
    int    kind;
    for (int n = 0; n < count; n++) begin
      kind = int'($urandom_range(99));
      it = beat_of(OP_POLL, sim_now, 16'(330 + $urandom_range(0, 12) - 6),
                   1'b1, sim_steps, sim_hour);
      if (kind < 3) begin
        it.opcode = OP_START;
        it.temp_valid = ($urandom_range(3) != 0);
      end else if (kind < 6) begin
        it.opcode = OP_WAKE;
      end else if (kind < 12) begin
        it.opcode = (kind < 7) ? OP_SPARE : OP_POLL;
        it.now = $urandom;
        it.temp = 16'($urandom);
        it.temp_valid = 1'($urandom);
        it.steps = $urandom;
        it.hour = 5'($urandom_range(0, 31));
      end else begin
        sim_now = sim_now + 32'($urandom_range(600, 1200));
        if ($urandom_range(49) == 0) sim_now = sim_now - 32'($urandom_range(0, 5000));
        if ($urandom_range(3) == 0) sim_hour = (sim_hour >= 5'd23) ? 5'd0 : sim_hour + 5'd1;
        if ($urandom_range(39) == 0) sim_hour = 5'($urandom_range(24, 31));
        if ($urandom_range(3) == 0) sim_steps = sim_steps + 32'($urandom_range(1, 300));
        if (kind < 17 && dip_left == 0) dip_left = int'($urandom_range(1, 4));
        it.now = sim_now;
        it.steps = sim_steps;
        it.hour = sim_hour;
        it.temp_valid = ($urandom_range(9) != 0);
        if (dip_left > 0) begin
          dip_left--;
          it.temp = 16'(330 - $urandom_range(10, 400));
          it.temp_valid = 1'b1;
        end
      end
      offer(it);
    end
  endtask

  initial begin
    status_t s;
    trk = '0;
    regs.off_drop = 10'd30;
    regs.min_sleep = 17'd1800;
    regs.night_start = 5'd22;
    regs.night_end = 5'd8;
    regs.nap_start = 5'd13;
    regs.nap_end = 5'd18;
    regs.night_polls = 8'd3;
    regs.nap_polls = 8'd2;
    sim_now = 32'd1700000000;
    sim_steps = 32'd0;
    sim_hour = 5'd20;
    dip_left = 0;

    s = '0;
    s.longest_wear = 32'd1000;
    add_row(beat_of(OP_POLL, 32'd1000, 16'd0, 1'b0, 32'd0, 5'd12), 1'b1, s);
    // An unused opcode leaves everything as it was.
    add_row(beat_of(OP_SPARE, 32'd5, 16'h7fff, 1'b1, 32'hffffffff, 5'd31), 1'b1, s);
    add_row(beat_of(OP_START, 32'd100000, 16'd330, 1'b1, 32'd0, 5'd12), 1'b1,
            started(32'd100000, 16'd330));
    add_row(beat_of(OP_POLL, 32'd100900, 16'd330, 1'b1, 32'd10, 5'd12), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd101800, 16'd331, 1'b1, 32'd10, 5'd23), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd102700, 16'd329, 1'b1, 32'd10, 5'd23), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd103600, 16'd330, 1'b1, 32'd10, 5'd0), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd104500, 16'd330, 1'b0, 32'd10, 5'd2), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd105400, 16'd330, 1'b1, 32'd25, 5'd7), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd106300, 16'd200, 1'b1, 32'd25, 5'd10), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd107200, 16'd150, 1'b1, 32'd25, 5'd10), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd108100, 16'd330, 1'b1, 32'd25, 5'd10), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd109000, 16'd331, 1'b1, 32'd25, 5'd14), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd109900, 16'd331, 1'b1, 32'd25, 5'd15), 1'b0, '0);
    // Manual wake while asleep keeps the sleep start.
    add_row(beat_of(OP_WAKE, 32'd110000, 16'd0, 1'b0, 32'd0, 5'd0), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd110900, NO_READING, 1'b1, 32'd25, 5'd31), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd50, 16'd330, 1'b1, 32'd25, 5'd23), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd51000, 16'h7fff, 1'b1, 32'd25, 5'd16), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd51900, 16'h8001, 1'b1, 32'd25, 5'd16), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd52800, 16'h8001, 1'b1, 32'd25, 5'd16), 1'b0, '0);
    add_row(beat_of(OP_START, 32'hffffffff, NO_READING, 1'b1, 32'd0, 5'd0), 1'b1,
            started(32'hffffffff, 16'd0));
    add_row(beat_of(OP_POLL, 32'd0, 16'hffff, 1'b1, 32'hffffffff, 5'd0), 1'b0, '0);
    // Still poll near zero: the backdated start wraps round.
    add_row(beat_of(OP_POLL, 32'd100, 16'hffff, 1'b1, 32'hffffffff, 5'd0), 1'b0, '0);
    // A deep dip with too few samples for a baseline is not off wrist.
    add_row(beat_of(OP_POLL, 32'd200, 16'hfe70, 1'b1, 32'hffffffff, 5'd1), 1'b0, '0);
    add_row(beat_of(OP_POLL, 32'd300, 16'd0, 1'b0, 32'hffffffff, 5'd3), 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      pinned_q.push_back(plan[i]);
      offer(plan[i].it);
    end
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          // Zero thresholds and an always-open night window.
          send_gap_pct = 53;
          stall_pct = 0;
          program_regs('0, '0, '0, '0, '0, '0, '0, '0);
        end
        2: begin
          // All ones: every register keeps only its own width.
          send_gap_pct = 0;
          stall_pct = 53;
          program_regs('1, '1, '1, '1, '1, '1, '1, '1);
        end
        3: begin
          send_gap_pct = 31;
          stall_pct = 31;
          write_q.push_back({REG_SPARE, 17'($urandom)});
          program_regs(17'($urandom_range(0, 1000)), 17'($urandom_range(0, 86400)),
                       17'($urandom_range(0, 23)), 17'($urandom_range(0, 23)),
                       17'($urandom_range(0, 23)), 17'($urandom_range(0, 23)),
                       17'($urandom_range(1, 5)), 17'($urandom_range(1, 5)));
        end
        default: begin
          send_gap_pct = 31;
          stall_pct = 31;
          program_regs(17'd50, 17'd900, 17'd21, 17'd6, 17'd12, 17'd16, 17'd2, 17'd1);
        end
      endcase
      run_random(PHASE_BEATS);
      settle();
    end

    if (mismatches == 0 && status_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/wst_pkg.sv
rtl/wst_cfg_regs.sv
rtl/wst_update.sv
rtl/wear_and_sleep_tracker.sv
rtl/wst_checker.sv
tb/wear_and_sleep_tracker_test.sv
